// ===== src/assert_macros.svh =====
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TTW_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttw check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define TTW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttw check failed");

`endif

// ===== src/ttw_pkg.sv =====
// shared types and constants of the text terminal writer
`default_nettype none

package ttw_pkg;

  // default screen geometry
  localparam int MAX_COLUMNS_DEF = 128;
  localparam int MAX_ROWS_DEF    = 64;

  // fixed field widths
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 24;
  localparam int CELL_W  = CHAR_W + 2 * COLOR_W;
  localparam int TCOL_W  = 7;
  localparam int TROW_W  = 6;
  localparam int CFG_COLS_W = 8;
  localparam int CFG_ROWS_W = 7;

  // compare widths that hold the active size plus one
  localparam int CMP_COL_W = 9;
  localparam int CMP_ROW_W = 8;

  // stream widths
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 72;
  localparam int RES_W       = CELL_W + TCOL_W + TROW_W + 1;
  localparam int OUT_PAD_W   = OUT_TDATA_W - RES_W;

  // configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // character codes
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

  // register indexes
  localparam logic [1:0] REG_NUM_COLUMNS = 2'd0;
  localparam logic [1:0] REG_NUM_ROWS    = 2'd1;
  localparam logic [1:0] REG_FG_COLOR    = 2'd2;
  localparam logic [1:0] REG_BG_COLOR    = 2'd3;

  // register reset values
  localparam logic [CFG_COLS_W-1:0] NUM_COLUMNS_RST = 8'd80;
  localparam logic [CFG_ROWS_W-1:0] NUM_ROWS_RST    = 7'd40;
  localparam logic [COLOR_W-1:0]    FG_COLOR_RST    = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0]    BG_COLOR_RST    = 24'h000000;

  // item kinds
  typedef enum logic [1:0] {
    CMD_WRITE      = 2'd0,
    CMD_SET_CURSOR = 2'd1,
    CMD_READ_CELL  = 2'd2
  } cmd_t;

  // one result beat, packed lowest field last
  typedef struct packed {
    logic                scrolled;
    logic [TROW_W-1:0]   cursor_row;
    logic [TCOL_W-1:0]   cursor_column;
    logic [COLOR_W-1:0]  cell_bg;
    logic [COLOR_W-1:0]  cell_fg;
    logic [CHAR_W-1:0]   cell_char;
  } res_t;

endpackage

`default_nettype wire

// ===== src/text_terminal_writer.sv =====
// text-mode screen store with cursor, scroll and cell readback
// write, newline, set cursor: one item per cycle while the output register is free
// read cell: result from the registered screen memory read, input held off till then
// scroll: one cell moved per cycle over the memory's read and write ports
// reset: in_tready stays low while the whole screen is zeroed
// a finished result waits in the output register while the next beat is taken
`default_nettype none

module text_terminal_writer #(
  parameter int MAX_COLUMNS = ttw_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = ttw_pkg::MAX_ROWS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // char_code [7:0], target_column [14:8], target_row [20:15], zero [23:21]
  input  wire logic [ttw_pkg::IN_TDATA_W-1:0]    in_tdata,
  // command [1:0]
  input  wire logic [ttw_pkg::IN_TUSER_W-1:0]    in_tuser,
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // cell_char [7:0], cell_fg [31:8], cell_bg [55:32], cursor_column [62:56],
  // cursor_row [68:63], scrolled [69], zero [71:70]
  output logic [ttw_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // configuration port
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [ttw_pkg::APB_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [ttw_pkg::APB_DATA_W-1:0]    cfg_pwdata,
  output logic [ttw_pkg::APB_DATA_W-1:0]         cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CC_W   = ttw_pkg::CMP_COL_W;
  localparam int RC_W   = ttw_pkg::CMP_ROW_W;
  localparam int CELL_W = ttw_pkg::CELL_W;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_READ   = 6'b000100,
    ST_SCROLL = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_PUSH   = 6'b100000
  } state_t;

  // linear cell address
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] c,
                                                   input logic [ROW_W-1:0] r);
    return ADDR_W'(r) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(c);
  endfunction

  state_t state_r, state_nxt;

  logic [ttw_pkg::CFG_COLS_W-1:0] num_columns_r;
  logic [ttw_pkg::CFG_ROWS_W-1:0] num_rows_r;
  logic [ttw_pkg::COLOR_W-1:0]    fg_color_r;
  logic [ttw_pkg::COLOR_W-1:0]    bg_color_r;

  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [COL_W-1:0]  scol_r, scol_nxt;
  logic [ROW_W-1:0]  srow_r, srow_nxt;
  logic              swr_pend_r;
  logic [ADDR_W-1:0] swr_addr_r;
  logic              swr_space_r;

  ttw_pkg::res_t stage_r, stage_nxt;
  ttw_pkg::res_t out_res_r;
  logic          out_valid_r;

  // screen memory
  logic [CELL_W-1:0] screen_mem [DEPTH];
  logic [CELL_W-1:0] mem_q_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  // active area
  logic [CC_W-1:0] cols;
  logic [RC_W-1:0] rows;

  // decoded input beat
  logic                       in_accept;
  ttw_pkg::cmd_t              cmd;
  logic [ttw_pkg::CHAR_W-1:0] char_in;
  logic [ttw_pkg::TCOL_W-1:0] tcol;
  logic [ttw_pkg::TROW_W-1:0] trow;
  logic [CC_W-1:0]            tcol_cl, col_cl, col_inc;
  logic [RC_W-1:0]            trow_cl, row_cl, row_inc;

  // item outcome
  logic              acc_scroll, acc_read, acc_cellwr;
  logic [CC_W-1:0]   acc_col;
  logic [RC_W-1:0]   acc_row;
  logic [CELL_W-1:0] acc_cell;
  ttw_pkg::res_t     acc_res;

  logic          s_last_col, s_last_row;
  logic [ROW_W-1:0] srd_row;
  logic          res_fire, out_free, out_load;
  ttw_pkg::res_t res;
  logic          cfg_we;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_columns_r <= ttw_pkg::NUM_COLUMNS_RST;
      num_rows_r    <= ttw_pkg::NUM_ROWS_RST;
      fg_color_r    <= ttw_pkg::FG_COLOR_RST;
      bg_color_r    <= ttw_pkg::BG_COLOR_RST;
    end else if (cfg_we) begin
      case (cfg_paddr[3:2])
        ttw_pkg::REG_NUM_COLUMNS: num_columns_r <= cfg_pwdata[ttw_pkg::CFG_COLS_W-1:0];
        ttw_pkg::REG_NUM_ROWS:    num_rows_r    <= cfg_pwdata[ttw_pkg::CFG_ROWS_W-1:0];
        ttw_pkg::REG_FG_COLOR:    fg_color_r    <= cfg_pwdata[ttw_pkg::COLOR_W-1:0];
        ttw_pkg::REG_BG_COLOR:    bg_color_r    <= cfg_pwdata[ttw_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_paddr[3:2])
      ttw_pkg::REG_NUM_COLUMNS: cfg_prdata = ttw_pkg::APB_DATA_W'(num_columns_r);
      ttw_pkg::REG_NUM_ROWS:    cfg_prdata = ttw_pkg::APB_DATA_W'(num_rows_r);
      ttw_pkg::REG_FG_COLOR:    cfg_prdata = ttw_pkg::APB_DATA_W'(fg_color_r);
      ttw_pkg::REG_BG_COLOR:    cfg_prdata = ttw_pkg::APB_DATA_W'(bg_color_r);
      default:                  cfg_prdata = '0;
    endcase
  end

  // active size clamped to 1..max
  always_comb begin
    if (num_columns_r == '0) begin
      cols = CC_W'(1);
    end else if (CC_W'(num_columns_r) > CC_W'(MAX_COLUMNS)) begin
      cols = CC_W'(MAX_COLUMNS);
    end else begin
      cols = CC_W'(num_columns_r);
    end
    if (num_rows_r == '0) begin
      rows = RC_W'(1);
    end else if (RC_W'(num_rows_r) > RC_W'(MAX_ROWS)) begin
      rows = RC_W'(MAX_ROWS);
    end else begin
      rows = RC_W'(num_rows_r);
    end
  end

  // input beat fields and clamped positions
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign cmd       = ttw_pkg::cmd_t'(in_tuser);
  assign char_in   = in_tdata[7:0];
  assign tcol      = in_tdata[14:8];
  assign trow      = in_tdata[20:15];

  assign tcol_cl = (CC_W'(tcol) >= cols) ? cols - CC_W'(1) : CC_W'(tcol);
  assign trow_cl = (RC_W'(trow) >= rows) ? rows - RC_W'(1) : RC_W'(trow);
  assign col_cl  = (CC_W'(cur_col_r) >= cols) ? cols - CC_W'(1) : CC_W'(cur_col_r);
  assign row_cl  = (RC_W'(cur_row_r) >= rows) ? rows - RC_W'(1) : RC_W'(cur_row_r);
  assign col_inc = col_cl + CC_W'(1);
  assign row_inc = row_cl + RC_W'(1);

  // item outcome: cursor move, cell write, scroll or read request
  always_comb begin
    acc_col    = col_cl;
    acc_row    = row_cl;
    acc_scroll = 1'b0;
    acc_read   = 1'b0;
    acc_cellwr = 1'b0;
    acc_cell   = '0;
    case (cmd)
      ttw_pkg::CMD_WRITE: begin
        if (char_in != ttw_pkg::NEWLINE_CODE) begin
          acc_cellwr = 1'b1;
          acc_cell   = {char_in, fg_color_r, bg_color_r};
        end
        if ((char_in == ttw_pkg::NEWLINE_CODE) || (col_inc >= cols)) begin
          acc_col = '0;
          if (row_inc >= rows) begin
            acc_scroll = 1'b1;
            acc_row    = rows - RC_W'(1);
          end else begin
            acc_row = row_inc;
          end
        end else begin
          acc_col = col_inc;
        end
      end
      ttw_pkg::CMD_SET_CURSOR: begin
        acc_col = tcol_cl;
        acc_row = trow_cl;
      end
      ttw_pkg::CMD_READ_CELL: begin
        acc_read = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    acc_res.cell_char     = acc_cell[CELL_W-1 -: ttw_pkg::CHAR_W];
    acc_res.cell_fg       = acc_cell[2*ttw_pkg::COLOR_W-1 -: ttw_pkg::COLOR_W];
    acc_res.cell_bg       = acc_cell[ttw_pkg::COLOR_W-1:0];
    acc_res.cursor_column = acc_col[ttw_pkg::TCOL_W-1:0];
    acc_res.cursor_row    = acc_row[ttw_pkg::TROW_W-1:0];
    acc_res.scrolled      = acc_scroll;
  end

  // scroll sweep position: each cell takes the one below, the last row gets spaces
  assign s_last_col = (CC_W'(scol_r) == cols - CC_W'(1));
  assign s_last_row = (RC_W'(srow_r) == rows - RC_W'(1));
  assign srd_row    = s_last_row ? srow_r : srow_r + ROW_W'(1);

  // result selection
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    res_fire = 1'b0;
    res      = stage_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && !acc_scroll && !acc_read) begin
          res_fire = 1'b1;
          res      = acc_res;
        end
      end
      ST_READ: begin
        res_fire      = 1'b1;
        res.cell_char = mem_q_r[CELL_W-1 -: ttw_pkg::CHAR_W];
        res.cell_fg   = mem_q_r[2*ttw_pkg::COLOR_W-1 -: ttw_pkg::COLOR_W];
        res.cell_bg   = mem_q_r[ttw_pkg::COLOR_W-1:0];
      end
      ST_DRAIN: res_fire = 1'b1;
      ST_PUSH:  res_fire = 1'b1;
      default: ;
    endcase
  end

  assign out_load = res_fire && out_free;

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cur_col_nxt  = cur_col_r;
    cur_row_nxt  = cur_row_r;
    clr_addr_nxt = clr_addr_r;
    scol_nxt     = scol_r;
    srow_nxt     = srow_r;
    stage_nxt    = stage_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          cur_col_nxt = COL_W'(acc_col);
          cur_row_nxt = ROW_W'(acc_row);
          stage_nxt   = acc_res;
          scol_nxt    = '0;
          srow_nxt    = '0;
          if (acc_scroll) begin
            state_nxt = ST_SCROLL;
          end else if (acc_read) begin
            state_nxt = ST_READ;
          end else if (!out_free) begin
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_READ: begin
        stage_nxt = res;
        state_nxt = out_free ? ST_IDLE : ST_PUSH;
      end
      ST_SCROLL: begin
        if (s_last_col) begin
          scol_nxt = '0;
          srow_nxt = srow_r + ROW_W'(1);
          if (s_last_row) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          scol_nxt = scol_r + COL_W'(1);
        end
      end
      ST_DRAIN: state_nxt = out_free ? ST_IDLE : ST_PUSH;
      ST_PUSH:  state_nxt = out_free ? ST_IDLE : ST_PUSH;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      clr_addr_r  <= '0;
      scol_r      <= '0;
      srow_r      <= '0;
      swr_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      clr_addr_r  <= clr_addr_nxt;
      scol_r      <= scol_nxt;
      srow_r      <= srow_nxt;
      swr_pend_r  <= (state_r == ST_SCROLL);
      out_valid_r <= out_load || (out_valid_r && !out_tready);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    stage_r     <= stage_nxt;
    swr_addr_r  <= cell_addr(scol_r, srow_r);
    swr_space_r <= s_last_row;
    if (out_load) begin
      out_res_r <= res;
    end
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_addr(COL_W'(col_cl), ROW_W'(row_cl));
    mem_wdata = acc_cell;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (swr_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = swr_addr_r;
      mem_wdata = swr_space_r ? {ttw_pkg::SPACE_CODE, mem_q_r[2*ttw_pkg::COLOR_W-1:0]}
                              : mem_q_r;
    end else if (in_accept && acc_cellwr) begin
      mem_we = 1'b1;
    end
  end

  assign mem_raddr = (state_r == ST_SCROLL) ? cell_addr(scol_r, srd_row)
                                            : cell_addr(COL_W'(tcol_cl), ROW_W'(trow_cl));

  // screen memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    mem_q_r <= screen_mem[mem_raddr];
  end

  // output beat
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{ttw_pkg::OUT_PAD_W{1'b0}}, out_res_r};

endmodule

`default_nettype wire

// ===== src/ttw_checker.sv =====
// port-level checks for the text terminal writer, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module ttw_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [ttw_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // stalled result beat keeps its payload
  `TTW_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // a scroll always leaves the cursor in column zero
  `TTW_ASSERT_IMPL(a_scroll_col0, out_tvalid && out_tdata[69], out_tdata[62:56] == 7'd0)

  // a newline is never stored, so no cell reports it
  `TTW_ASSERT_IMPL(a_no_newline_cell, out_tvalid, out_tdata[7:0] != ttw_pkg::NEWLINE_CODE)

  // the screen clear after reset holds off input beats
  `TTW_ASSERT_IMPL(a_clear_after_reset, !$past(rst_n), !in_tready)

  // no input beat is taken in the first cycle after reset
  `TTW_ASSERT_IMPL(a_ready_idle_out, in_tvalid && in_tready, !$past(!rst_n))

endmodule

bind text_terminal_writer ttw_checker u_ttw_checker (.*);

`default_nettype wire

// ===== dv/ttw_screen_checker.sv =====
// screen model and result checker for the text terminal writer
`timescale 1ns / 1ps

module ttw_screen_checker
  import ttw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [APB_ADDR_W-1:0]  cfg_paddr,
  input  logic [APB_DATA_W-1:0]  cfg_pwdata,
  input  logic                   cfg_pready,
  output int                     pending,
  output int                     fail_count
);

  localparam int CELL_COUNT = MAX_COLUMNS_DEF * MAX_ROWS_DEF;
  localparam int PRINT_CAP  = 40;

  // model copy of the screen, cursor and registers
  logic [CELL_W-1:0]     screen [CELL_COUNT];
  int                    cur_col;
  int                    cur_row;
  logic [CFG_COLS_W-1:0] cols_reg;
  logic [CFG_ROWS_W-1:0] rows_reg;
  logic [COLOR_W-1:0]    fg_reg;
  logic [COLOR_W-1:0]    bg_reg;

  res_t cell_results_due [$];
  res_t want;
  res_t got;
  int   beat_no;

  initial begin
    pending    = 0;
    fail_count = 0;
    beat_no    = 0;
  end

  task automatic report(input string what, input logic [31:0] exp_val,
                        input logic [31:0] act_val);
    if (fail_count < PRINT_CAP) begin
      $display("%0t ns: result beat %0d, %s expected %0h, got %0h",
               $time, beat_no, what, exp_val, act_val);
    end
    fail_count++;
  endtask

  // register value clamped into 1..limit
  function automatic int active_span(input int raw, input int limit);
    if (raw < 1) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  // cursor to the start of the next row, scrolling past the last row
  task automatic advance_line(input int cols, input int rows, inout logic rolled);
    cur_col = 0;
    cur_row++;
    if (cur_row >= rows) begin
      for (int r = 1; r < rows; r++) begin
        for (int c = 0; c < cols; c++) begin
          screen[(r - 1) * MAX_COLUMNS_DEF + c] = screen[r * MAX_COLUMNS_DEF + c];
        end
      end
      for (int c = 0; c < cols; c++) begin
        screen[(rows - 1) * MAX_COLUMNS_DEF + c][CELL_W-1 -: CHAR_W] = SPACE_CODE;
      end
      cur_row = rows - 1;
      rolled  = 1'b1;
    end
  endtask

  // applies one input beat to the model and returns the cell result it gives
  task automatic screen_step(input logic [1:0] cmd, input logic [CHAR_W-1:0] code,
                             input int tcol, input int trow, output res_t r);
    int                cols;
    int                rows;
    logic [CELL_W-1:0] cell_val;
    logic              rolled;
    cols     = active_span(int'(cols_reg), MAX_COLUMNS_DEF);
    rows     = active_span(int'(rows_reg), MAX_ROWS_DEF);
    cell_val = '0;
    rolled   = 1'b0;
    // stale cursor after a shrink
    if (cur_col >= cols) cur_col = cols - 1;
    if (cur_row >= rows) cur_row = rows - 1;
    case (cmd)
      CMD_WRITE: begin
        if (code == NEWLINE_CODE) begin
          advance_line(cols, rows, rolled);
        end else begin
          cell_val = {code, fg_reg, bg_reg};
          screen[cur_row * MAX_COLUMNS_DEF + cur_col] = cell_val;
          cur_col++;
          if (cur_col >= cols) advance_line(cols, rows, rolled);
        end
      end
      CMD_SET_CURSOR: begin
        cur_col = (tcol < cols) ? tcol : cols - 1;
        cur_row = (trow < rows) ? trow : rows - 1;
      end
      CMD_READ_CELL: begin
        if (tcol >= cols) tcol = cols - 1;
        if (trow >= rows) trow = rows - 1;
        cell_val = screen[trow * MAX_COLUMNS_DEF + tcol];
      end
      default: ;
    endcase
    r.cell_char     = cell_val[CELL_W-1 -: CHAR_W];
    r.cell_fg       = cell_val[2*COLOR_W-1 -: COLOR_W];
    r.cell_bg       = cell_val[COLOR_W-1:0];
    r.cursor_column = cur_col[TCOL_W-1:0];
    r.cursor_row    = cur_row[TROW_W-1:0];
    r.scrolled      = rolled;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (screen[i]) screen[i] = '0;
      cur_col  = 0;
      cur_row  = 0;
      cols_reg = NUM_COLUMNS_RST;
      rows_reg = NUM_ROWS_RST;
      fg_reg   = FG_COLOR_RST;
      bg_reg   = BG_COLOR_RST;
      cell_results_due.delete();
    end else begin
      // result beat against the oldest expectation
      if (out_tvalid && out_tready) begin
        got = out_tdata[RES_W-1:0];
        if (cell_results_due.size() == 0) begin
          report("beat with nothing pending, data", '0, out_tdata[31:0]);
        end else begin
          want = cell_results_due.pop_front();
          if (got.cell_char != want.cell_char)
            report("cell_char", 32'(want.cell_char), 32'(got.cell_char));
          if (got.cell_fg != want.cell_fg)
            report("cell_fg", 32'(want.cell_fg), 32'(got.cell_fg));
          if (got.cell_bg != want.cell_bg)
            report("cell_bg", 32'(want.cell_bg), 32'(got.cell_bg));
          if (got.cursor_column != want.cursor_column)
            report("cursor_column", 32'(want.cursor_column), 32'(got.cursor_column));
          if (got.cursor_row != want.cursor_row)
            report("cursor_row", 32'(want.cursor_row), 32'(got.cursor_row));
          if (got.scrolled != want.scrolled)
            report("scrolled", 32'(want.scrolled), 32'(got.scrolled));
          if (out_tdata[OUT_TDATA_W-1:RES_W] != '0)
            report("pad bits", '0, 32'(out_tdata[OUT_TDATA_W-1:RES_W]));
        end
        beat_no++;
      end
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_NUM_COLUMNS: cols_reg = cfg_pwdata[CFG_COLS_W-1:0];
          REG_NUM_ROWS:    rows_reg = cfg_pwdata[CFG_ROWS_W-1:0];
          REG_FG_COLOR:    fg_reg   = cfg_pwdata[COLOR_W-1:0];
          REG_BG_COLOR:    bg_reg   = cfg_pwdata[COLOR_W-1:0];
          default: ;
        endcase
      end
      // input beat through the model
      if (in_tvalid && in_tready) begin
        screen_step(in_tuser, in_tdata[7:0], int'(in_tdata[14:8]), int'(in_tdata[20:15]),
                    want);
        cell_results_due.push_back(want);
      end
    end
    pending <= cell_results_due.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// top of the text terminal writer testbench: stimulus, handshakes and verdict
`timescale 1ns / 1ps

module tb_top;
  import ttw_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         STALL_LIMIT = 50000;
  localparam int         HOLD_CYCLES = 300;
  localparam int         DRAIN_GAP   = 8;
  localparam int         TAIL_CYCLES = 40;
  localparam int         PHASES      = 14;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [APB_ADDR_W-1:0]  cfg_paddr;
  logic [APB_DATA_W-1:0]  cfg_pwdata;
  logic [APB_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;
  int                     pending;
  int                     fail_count;

  // stimulus knobs shared with the sink
  int span_cols;
  int span_rows;
  bit src_quiet;
  bit sink_quiet;
  int sink_hold;

  text_terminal_writer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  ttw_screen_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one input beat after a random gap, none when the source is quiet
  task automatic send_item(input logic [1:0] cmd, input logic [CHAR_W-1:0] code,
                           input logic [TCOL_W-1:0] col, input logic [TROW_W-1:0] row);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, row, col, code};
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering and wait until every result is back and the block is free
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0 || !in_tready) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  // setup and access cycle of one register write
  task automatic cfg_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // new geometry and colors, written while the block is idle
  task automatic set_screen(input logic [CFG_COLS_W-1:0] cols_raw,
                            input logic [CFG_ROWS_W-1:0] rows_raw,
                            input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
    wait_idle();
    cfg_write(REG_NUM_COLUMNS, {{(APB_DATA_W-CFG_COLS_W){1'b0}}, cols_raw});
    cfg_write(REG_NUM_ROWS, {{(APB_DATA_W-CFG_ROWS_W){1'b0}}, rows_raw});
    cfg_write(REG_FG_COLOR, {{(APB_DATA_W-COLOR_W){1'b0}}, fg});
    cfg_write(REG_BG_COLOR, {{(APB_DATA_W-COLOR_W){1'b0}}, bg});
    span_cols = (cols_raw == 0) ? 1 :
                ((int'(cols_raw) > MAX_COLUMNS_DEF) ? MAX_COLUMNS_DEF : int'(cols_raw));
    span_rows = (rows_raw == 0) ? 1 :
                ((int'(rows_raw) > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_raw));
  endtask

  // targets mostly inside the screen, sometimes anywhere in the field
  function automatic logic [TCOL_W-1:0] pick_col();
    if ($urandom_range(0, 3) != 0) return TCOL_W'($urandom_range(0, span_cols - 1));
    return TCOL_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [TROW_W-1:0] pick_row();
    if ($urandom_range(0, 3) != 0) return TROW_W'($urandom_range(0, span_rows - 1));
    return TROW_W'($urandom_range(0, 63));
  endfunction

  // one random run: text with an optional newline, a cursor move, a read, or noise
  task automatic random_burst(inout int sent);
    int                pick;
    int                len;
    logic [CHAR_W-1:0] code;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      len = $urandom_range(1, 10);
      repeat (len) begin
        code = CHAR_W'($urandom_range(0, 1) ? $urandom_range(32, 126)
                                            : $urandom_range(0, 255));
        send_item(CMD_WRITE, code, TCOL_W'($urandom_range(0, 127)),
                  TROW_W'($urandom_range(0, 63)));
        sent++;
      end
      if ($urandom_range(0, 2) == 0) begin
        send_item(CMD_WRITE, NEWLINE_CODE, TCOL_W'($urandom_range(0, 127)),
                  TROW_W'($urandom_range(0, 63)));
        sent++;
      end
    end else if (pick < 70) begin
      send_item(CMD_SET_CURSOR, CHAR_W'($urandom_range(0, 255)), pick_col(), pick_row());
      sent++;
    end else if (pick < 94) begin
      send_item(CMD_READ_CELL, CHAR_W'($urandom_range(0, 255)), pick_col(), pick_row());
      sent++;
    end else begin
      send_item(CMD_UNUSED, CHAR_W'($urandom_range(0, 255)), TCOL_W'($urandom_range(0, 127)),
                TROW_W'($urandom_range(0, 63)));
      sent++;
    end
  endtask

  // result sink with random stalls and one long hold-off on request
  initial begin : sink
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        out_tready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end
      stall = sink_quiet ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
    end
  end

  // ends the run when no beat moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int phase;
    int budget;
    int sent;
    bit big;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    span_cols   = int'(NUM_COLUMNS_RST);
    span_rows   = int'(NUM_ROWS_RST);
    src_quiet   = 1'b0;
    sink_quiet  = 1'b0;
    sink_hold   = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // screen clearing after reset
    while (!in_tready) @(posedge clk);

    // reset geometry: cleared cells, clamped targets, wrap into a scroll
    send_item(CMD_READ_CELL, 8'h00, 7'd0, 6'd0);
    send_item(CMD_READ_CELL, 8'h00, 7'd127, 6'd63);
    send_item(CMD_SET_CURSOR, 8'h00, 7'd127, 6'd63);
    send_item(CMD_WRITE, 8'h41, 7'd0, 6'd0);
    send_item(CMD_READ_CELL, 8'h00, 7'd79, 6'd38);
    send_item(CMD_READ_CELL, 8'h00, 7'd79, 6'd39);
    send_item(CMD_WRITE, 8'h00, 7'd0, 6'd0);
    send_item(CMD_WRITE, 8'hFF, 7'd0, 6'd0);
    send_item(CMD_WRITE, NEWLINE_CODE, 7'd0, 6'd0);
    send_item(CMD_UNUSED, 8'hFF, 7'd127, 6'd63);
    send_item(CMD_SET_CURSOR, 8'h00, 7'd0, 6'd0);
    send_item(CMD_WRITE, 8'h7E, 7'd0, 6'd0);
    send_item(CMD_READ_CELL, 8'h00, 7'd0, 6'd0);

    // smallest screen: stale cursor, scroll of a single cell
    set_screen(8'd0, 7'd0, 24'h000000, 24'hFFFFFF);
    send_item(CMD_READ_CELL, 8'h00, 7'd0, 6'd0);
    send_item(CMD_WRITE, 8'h78, 7'd0, 6'd0);
    send_item(CMD_READ_CELL, 8'h00, 7'd5, 6'd5);
    send_item(CMD_WRITE, NEWLINE_CODE, 7'd0, 6'd0);
    send_item(CMD_SET_CURSOR, 8'h00, 7'd3, 6'd3);

    // register maximum, clamped to the full screen, full scroll
    set_screen(8'hFF, 7'h7F, 24'h00FF00, 24'hFF00FF);
    send_item(CMD_SET_CURSOR, 8'h00, 7'd127, 6'd63);
    send_item(CMD_WRITE, 8'hC3, 7'd0, 6'd0);
    send_item(CMD_READ_CELL, 8'h00, 7'd127, 6'd62);
    send_item(CMD_READ_CELL, 8'h00, 7'd0, 6'd63);

    // random phases, mostly small screens
    for (phase = 0; phase < PHASES; phase++) begin
      big = (phase == 4 || phase == 10);
      set_screen(CFG_COLS_W'(big ? $urandom_range(100, 255) : $urandom_range(0, 12)),
                 CFG_ROWS_W'(big ? $urandom_range(48, 127) : $urandom_range(0, 6)),
                 COLOR_W'((phase == 0) ? 24'h000000 : (phase == 1) ? 24'hFFFFFF
                                                    : $urandom_range(0, 24'hFFFFFF)),
                 COLOR_W'((phase == 0) ? 24'hFFFFFF : (phase == 1) ? 24'h000000
                                                    : $urandom_range(0, 24'hFFFFFF)));
      src_quiet  = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      // long sink hold-off while the source keeps offering
      if (phase == 2) begin
        src_quiet = 1'b1;
        sink_hold = HOLD_CYCLES;
      end
      budget = big ? 60 : 142;
      sent   = 0;
      while (sent < budget) random_burst(sent);
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
